// ===== src/alfs_pkg.sv =====
// Shared widths, request and status codes and the response record for the
// slot-store linked list. No dependencies.
package alfs_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int MODE_W       = 2;
   localparam int SLOT_W       = 6;
   localparam int HANDLE_W     = 32;
   localparam int STATUS_W     = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   used_slot;
      logic [HANDLE_W-1:0] slot_key;
      logic [HANDLE_W-1:0] slot_value;
      logic [SLOT_W-1:0]   next_slot;
      logic [SLOT_W-1:0]   prev_slot;
      logic [SLOT_W-1:0]   element_count;
   } rsp_type;

endpackage

// ===== src/alfs_ifs.sv =====
// Valid/ready channel interfaces for requests and responses of the
// slot-store linked list. Depends on alfs_pkg.
interface alfs_req_if;
   logic                           valid;
   logic                           ready;
   logic [alfs_pkg::MODE_W-1:0]    mode;
   logic [alfs_pkg::SLOT_W-1:0]    slot_index;
   logic [alfs_pkg::HANDLE_W-1:0]  key_handle;
   logic [alfs_pkg::HANDLE_W-1:0]  value_handle;

   modport source (output valid, output mode, output slot_index, output key_handle,
                   output value_handle, input ready);
   modport sink (input valid, input mode, input slot_index, input key_handle,
                 input value_handle, output ready);
endinterface

interface alfs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [alfs_pkg::STATUS_W-1:0]  status;
   logic [alfs_pkg::SLOT_W-1:0]    used_slot;
   logic [alfs_pkg::HANDLE_W-1:0]  slot_key;
   logic [alfs_pkg::HANDLE_W-1:0]  slot_value;
   logic [alfs_pkg::SLOT_W-1:0]    next_slot;
   logic [alfs_pkg::SLOT_W-1:0]    prev_slot;
   logic [alfs_pkg::SLOT_W-1:0]    element_count;

   modport source (output valid, output status, output used_slot, output slot_key,
                   output slot_value, output next_slot, output prev_slot,
                   output element_count, input ready);
   modport sink (input valid, input status, input used_slot, input slot_key,
                 input slot_value, input next_slot, input prev_slot,
                 input element_count, output ready);
endinterface

// ===== src/alfs_rsp_stage.sv =====
// Output register of the response channel: holds one finished response until
// it is taken. Depends on alfs_pkg and alfs_rsp_if.
module alfs_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  alfs_pkg::rsp_type data,
   output logic              can_load,
   alfs_rsp_if.source        rsp_ch
);

   logic              valid_ff;
   logic              valid_in;
   alfs_pkg::rsp_type data_ff;

   assign can_load = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.status        = data_ff.status;
   assign rsp_ch.used_slot     = data_ff.used_slot;
   assign rsp_ch.slot_key      = data_ff.slot_key;
   assign rsp_ch.slot_value    = data_ff.slot_value;
   assign rsp_ch.next_slot     = data_ff.next_slot;
   assign rsp_ch.prev_slot     = data_ff.prev_slot;
   assign rsp_ch.element_count = data_ff.element_count;

endmodule

// ===== src/array_linked_list_free_slots_core.sv =====
// Top level of the slot-store doubly linked list with a LIFO free chain.
// Depends on alfs_pkg, alfs_ifs (channel interfaces) and alfs_rsp_stage.
//
// The block keeps a circular doubly linked list in CAPACITY slots, slot 0
// being the sentinel whose next link is the front and whose prev link is the
// back. Unused slots form a last-in-first-out free chain through the next
// links. After reset the block runs a clearing pass over every slot that
// rebuilds the link memories; no request is taken during that time. Each
// request then occupies the block from the cycle in which it is accepted
// through the cycle in which its response is placed in a free output
// register: a read visits S_LOOK and S_DONE, an erase S_LOOK, S_ERA_W and
// S_DONE, an insert after a slot S_INS_A, S_INS_N, S_INS_W and S_DONE, an
// append S_APPEND before those, and a request rejected by the index check
// only S_DONE. These steps come from the single-port next-link memory: every
// link entry a request reads or changes is touched in a step of its own, and
// each read is registered. One request is worked on at a time; the next one
// is taken as soon as the previous response has been placed in the output
// register, even while that response still waits for the consumer. A full
// store answers an insert with status full rather than growing.
module array_linked_list_free_slots_core #(
   parameter int CAPACITY = alfs_pkg::CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   alfs_req_if.sink   req_ch,
   alfs_rsp_if.source rsp_ch
);

   localparam int                IDX_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0]  LAST  = IDX_W'(CAPACITY - 1);

   // Sequencer states.
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_APPEND = 4'd2;
   localparam logic [3:0] S_INS_A  = 4'd3;
   localparam logic [3:0] S_INS_N  = 4'd4;
   localparam logic [3:0] S_INS_W  = 4'd5;
   localparam logic [3:0] S_LOOK   = 4'd6;
   localparam logic [3:0] S_ERA_W  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   // Link memories. The next-link memory carries the in-use flag in its top
   // bit. The handle memory holds key and value side by side.
   logic [IDX_W:0]                      nxt_mem [CAPACITY];
   logic [IDX_W-1:0]                    prv_mem [CAPACITY];
   logic [2*alfs_pkg::HANDLE_W-1:0]     kv_mem  [CAPACITY];

   logic [IDX_W:0]                      nxt_q;
   logic [IDX_W-1:0]                    prv_q;
   logic [2*alfs_pkg::HANDLE_W-1:0]     kv_q;

   logic                                nxt_we;
   logic [IDX_W-1:0]                    nxt_addr;
   logic [IDX_W:0]                      nxt_wdata;
   logic                                prv_we;
   logic [IDX_W-1:0]                    prv_addr;
   logic [IDX_W-1:0]                    prv_wdata;
   logic                                kv_we;
   logic [IDX_W-1:0]                    kv_addr;

   // Sequencer and list state.
   logic [3:0]                          state_ff, state_in;
   logic [IDX_W-1:0]                    clr_ff, clr_in;
   logic [alfs_pkg::MODE_W-1:0]         mode_ff, mode_in;
   logic [IDX_W-1:0]                    slot_ff, slot_in;
   logic [IDX_W-1:0]                    a_ff, a_in;
   logic [IDX_W-1:0]                    succ_ff, succ_in;
   logic [alfs_pkg::HANDLE_W-1:0]       key_ff, key_in;
   logic [alfs_pkg::HANDLE_W-1:0]       val_ff, val_in;
   logic [alfs_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [IDX_W-1:0]                    free_head_ff, free_head_in;
   logic [IDX_W-1:0]                    count_ff, count_in;

   logic                                req_fire;
   logic [IDX_W-1:0]                    req_idx;
   logic                                req_beyond;
   logic [IDX_W-1:0]                    clr_link;
   logic                                rsp_can_load;
   logic                                rsp_load;
   alfs_pkg::rsp_type                   rsp_data;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_idx      = IDX_W'(req_ch.slot_index);
   assign req_beyond   = (32'(req_ch.slot_index) >= 32'(CAPACITY));
   assign clr_link     = ((clr_ff == '0) || (clr_ff == LAST)) ? '0 : clr_ff + 1'b1;

   // Memory ports: addresses and writes for each sequencer step.
   always_comb begin
      nxt_we    = 1'b0;
      nxt_addr  = a_ff;
      nxt_wdata = '0;
      prv_we    = 1'b0;
      prv_addr  = a_ff;
      prv_wdata = '0;
      kv_we     = 1'b0;
      kv_addr   = slot_ff;
      unique case (state_ff)
         S_CLEAR: begin
            nxt_we    = 1'b1;
            nxt_addr  = clr_ff;
            nxt_wdata = {clr_ff == '0, clr_link};
            prv_we    = 1'b1;
            prv_addr  = clr_ff;
         end
         S_IDLE: begin
            nxt_addr = req_idx;
            prv_addr = (req_ch.mode == alfs_pkg::MODE_APPEND) ? '0 : req_idx;
            kv_addr  = req_idx;
         end
         S_APPEND: begin
            nxt_addr = prv_q;
         end
         S_INS_A: begin
            nxt_addr = free_head_ff;
         end
         S_INS_N: begin
            // Link the new slot in after the anchor and before its successor.
            nxt_we    = 1'b1;
            nxt_addr  = a_ff;
            nxt_wdata = {1'b1, free_head_ff};
            prv_we    = 1'b1;
            prv_addr  = succ_ff;
            prv_wdata = free_head_ff;
            kv_we     = 1'b1;
            kv_addr   = free_head_ff;
         end
         S_INS_W: begin
            nxt_we    = 1'b1;
            nxt_addr  = slot_ff;
            nxt_wdata = {1'b1, succ_ff};
            prv_we    = 1'b1;
            prv_addr  = slot_ff;
            prv_wdata = a_ff;
         end
         S_LOOK: begin
            // Unlink: the neighbors of an in-use slot are in use themselves.
            if (nxt_q[IDX_W] && (mode_ff == alfs_pkg::MODE_ERASE)) begin
               nxt_we    = 1'b1;
               nxt_addr  = prv_q;
               nxt_wdata = {1'b1, nxt_q[IDX_W-1:0]};
               prv_we    = 1'b1;
               prv_addr  = nxt_q[IDX_W-1:0];
               prv_wdata = prv_q;
            end
         end
         S_ERA_W: begin
            nxt_we    = 1'b1;
            nxt_addr  = slot_ff;
            nxt_wdata = {1'b0, free_head_ff};
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         nxt_mem[nxt_addr] <= nxt_wdata;
      end
      nxt_q <= nxt_mem[nxt_addr];
   end

   always_ff @(posedge clock) begin
      if (prv_we) begin
         prv_mem[prv_addr] <= prv_wdata;
      end
      prv_q <= prv_mem[prv_addr];
   end

   always_ff @(posedge clock) begin
      if (kv_we) begin
         kv_mem[kv_addr] <= {key_ff, val_ff};
      end
      kv_q <= kv_mem[kv_addr];
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      mode_in      = mode_ff;
      slot_in      = slot_ff;
      a_in         = a_ff;
      succ_in      = succ_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      free_head_in = free_head_ff;
      count_in     = count_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               mode_in   = req_ch.mode;
               slot_in   = req_idx;
               a_in      = req_idx;
               key_in    = req_ch.key_handle;
               val_in    = req_ch.value_handle;
               status_in = alfs_pkg::ST_OK;
               if (((req_ch.mode != alfs_pkg::MODE_APPEND) && req_beyond) ||
                   ((req_ch.mode == alfs_pkg::MODE_ERASE) && (req_ch.slot_index == '0))) begin
                  status_in = alfs_pkg::ST_RANGE;
                  state_in  = S_DONE;
               end else if (req_ch.mode == alfs_pkg::MODE_INSERT) begin
                  state_in = S_INS_A;
               end else if (req_ch.mode == alfs_pkg::MODE_APPEND) begin
                  state_in = S_APPEND;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_APPEND: begin
            // The back of the list is the sentinel's predecessor.
            a_in     = prv_q;
            state_in = S_INS_A;
         end
         S_INS_A: begin
            if (!nxt_q[IDX_W]) begin
               status_in = alfs_pkg::ST_UNUSED;
               state_in  = S_DONE;
            end else if (free_head_ff == '0) begin
               status_in = alfs_pkg::ST_FULL;
               state_in  = S_DONE;
            end else begin
               succ_in  = nxt_q[IDX_W-1:0];
               state_in = S_INS_N;
            end
         end
         S_INS_N: begin
            slot_in      = free_head_ff;
            free_head_in = nxt_q[IDX_W-1:0];
            state_in     = S_INS_W;
         end
         S_INS_W: begin
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end
         S_LOOK: begin
            if (!nxt_q[IDX_W]) begin
               status_in = alfs_pkg::ST_UNUSED;
               state_in  = S_DONE;
            end else begin
               succ_in = nxt_q[IDX_W-1:0];
               a_in    = prv_q;
               // The sentinel carries no handles.
               if (slot_ff == '0) begin
                  key_in = '0;
                  val_in = '0;
               end else begin
                  key_in = kv_q[2*alfs_pkg::HANDLE_W-1:alfs_pkg::HANDLE_W];
                  val_in = kv_q[alfs_pkg::HANDLE_W-1:0];
               end
               state_in = (mode_ff == alfs_pkg::MODE_ERASE) ? S_ERA_W : S_DONE;
            end
         end
         S_ERA_W: begin
            free_head_in = slot_ff;
            count_in     = count_ff - 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (rsp_can_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= IDX_W'(1);
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      slot_ff   <= slot_in;
      a_ff      <= a_in;
      succ_ff   <= succ_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      status_ff <= status_in;
   end

   // Response assembly: an error reports zeros apart from status and count.
   always_comb begin
      rsp_data               = '0;
      rsp_data.status        = status_ff;
      rsp_data.element_count = alfs_pkg::SLOT_W'(count_ff);
      if (status_ff == alfs_pkg::ST_OK) begin
         rsp_data.used_slot  = alfs_pkg::SLOT_W'(slot_ff);
         rsp_data.slot_key   = key_ff;
         rsp_data.slot_value = val_ff;
         rsp_data.next_slot  = alfs_pkg::SLOT_W'(succ_ff);
         rsp_data.prev_slot  = alfs_pkg::SLOT_W'(a_ff);
      end
   end

   assign rsp_load = (state_ff == S_DONE) && rsp_can_load;

   alfs_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (rsp_load),
      .data     (rsp_data),
      .can_load (rsp_can_load),
      .rsp_ch   (rsp_ch)
   );

   // Every non-sentinel slot is either in the list or on the free chain, so
   // an empty chain means a full list. The count trails the free head by one
   // step during an insert.
   a_free_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_INS_W) |-> ((free_head_ff == '0) == (count_ff == LAST)))
      else $error("free chain and element count disagree");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST)
      else $error("element count beyond capacity");

   a_sentinel_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERA_W) |-> (slot_ff != '0))
      else $error("sentinel slot put on the free chain");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("request taken while another is in progress");

   a_load_once: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (state_ff == S_IDLE))
      else $error("response loaded without returning to idle");

endmodule
